[design/kret_pkg.sv]
// Shared types and constants for the keyed root entry table.
package kret_pkg;

  localparam int ENTRIES_DEF    = 16;
  localparam int KEY_BYTES_DEF  = 8;
  localparam int DATA_BYTES_DEF = 8;
  localparam int WORD_W         = 64;
  localparam int LEN_W          = 4;
  localparam int STATUS_W       = 3;

  typedef enum logic [1:0] {
    FN_SET = 2'd0,
    FN_GET = 2'd1,
    FN_DEL = 2'd2,
    FN_NOP = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_KEY   = 3'd1,
    ST_BAD_SIZE  = 3'd2,
    ST_EXISTS    = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DECIDE,
    S_VREAD,
    S_VWAIT,
    S_RESP
  } state_t;

endpackage

[design/kret_key_store.sv]
// Key memory with per-slot occupancy flags and a registered read port.
module kret_key_store import kret_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF,
  parameter int KW      = 8 * KEY_BYTES_DEF,
  localparam int IW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          ren,
  input  logic [IW-1:0] raddr,
  output logic [KW-1:0] rdata,
  output logic          rocc,
  input  logic          we,
  input  logic          clr,
  input  logic [IW-1:0] waddr,
  input  logic [KW-1:0] wdata
);

  logic [KW-1:0] keys [ENTRIES];
  logic [ENTRIES-1:0] occ;

  always_ff @(posedge clk) begin
    if (we) begin
      keys[waddr] <= wdata;
    end
    if (ren) begin
      rdata <= keys[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ  <= '0;
      rocc <= 1'b0;
    end else begin
      if (we) begin
        occ[waddr] <= 1'b1;
      end else if (clr) begin
        occ[waddr] <= 1'b0;
      end
      if (ren) begin
        rocc <= occ[raddr];
      end
    end
  end

endmodule

[design/kret_val_store.sv]
// Data memory with per-slot written flags; unwritten slots read as zero.
module kret_val_store import kret_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF,
  parameter int DW      = 8 * DATA_BYTES_DEF,
  localparam int IW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          ren,
  input  logic [IW-1:0] raddr,
  output logic [DW-1:0] rdata,
  input  logic          we,
  input  logic [IW-1:0] waddr,
  input  logic [DW-1:0] wdata
);

  logic [DW-1:0] vals [ENTRIES];
  logic [ENTRIES-1:0] written;
  logic [DW-1:0] mem_q;
  logic rd_ok;

  always_ff @(posedge clk) begin
    if (we) begin
      vals[waddr] <= wdata;
    end
    if (ren) begin
      mem_q <= vals[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_ok   <= 1'b0;
    end else begin
      if (we) begin
        written[waddr] <= 1'b1;
      end
      if (ren) begin
        rd_ok <= written[raddr];
      end
    end
  end

  assign rdata = rd_ok ? mem_q : '0;

endmodule

[design/kret_ctrl.sv]
// Request sequencer: key check, slot scan through one comparator, value read or update.
module kret_ctrl import kret_pkg::*; #(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int KEY_BYTES  = KEY_BYTES_DEF,
  parameter int DATA_BYTES = DATA_BYTES_DEF,
  localparam int IW        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int KW        = 8 * KEY_BYTES,
  localparam int DW        = 8 * DATA_BYTES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        func,
  input  logic [WORD_W-1:0] key_word,
  input  logic [LEN_W-1:0]  key_len,
  input  logic [WORD_W-1:0] write_data,
  input  logic [LEN_W-1:0]  byte_count,
  input  logic              create_only,
  output logic              out_valid,
  input  logic              out_stall,
  output status_t           res_status,
  output logic [DW-1:0]     res_data,
  output logic              key_ren,
  output logic [IW-1:0]     key_raddr,
  input  logic [KW-1:0]     key_rdata,
  input  logic              key_rocc,
  output logic              key_we,
  output logic              key_clr,
  output logic [IW-1:0]     key_waddr,
  output logic [KW-1:0]     key_wdata,
  output logic              val_ren,
  output logic [IW-1:0]     val_raddr,
  input  logic [DW-1:0]     val_rdata,
  output logic              val_we,
  output logic [IW-1:0]     val_waddr,
  output logic [DW-1:0]     val_wdata
);

  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

  state_t state, state_next;
  func_t fn_in;
  func_t fn;
  logic [IW-1:0] idx, ridx, fidx, fridx, tgt;
  logic rvld, found, freef, conly;
  logic [KW-1:0] key, eff;
  logic [DW-1:0] wd, mask, mask_in, res_rd;
  status_t st, pre_status;
  logic run, key_bad, size_bad, go_scan, accept, hit, slot_free;
  logic [7:0] kb;

  assign fn_in  = func_t'(func);
  assign accept = (state == S_IDLE) && in_valid;

  always_comb begin
    run = 1'b1;
    eff = '0;
    kb  = 8'd0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      kb  = key_word[8*i +: 8];
      run = run && (kb != 8'd0) && (LEN_W'(i) < key_len);
      eff[8*i +: 8] = run ? kb : 8'd0;
    end
  end

  always_comb begin
    mask_in = '0;
    for (int i = 0; i < DATA_BYTES; i++) begin
      mask_in[8*i +: 8] = (LEN_W'(i) < byte_count) ? 8'hFF : 8'h00;
    end
  end

  assign key_bad  = (key_len == '0) || (key_len >= LEN_W'(KEY_BYTES)) || (eff == '0);
  assign size_bad = byte_count > LEN_W'(DATA_BYTES);

  always_comb begin
    pre_status = ST_OK;
    go_scan    = 1'b0;
    if (fn_in == FN_NOP) begin
      pre_status = ST_OK;
    end else if (key_bad) begin
      pre_status = ST_BAD_KEY;
    end else if ((fn_in == FN_SET) && size_bad) begin
      pre_status = ST_BAD_SIZE;
    end else begin
      go_scan = 1'b1;
    end
  end

  // shared comparator
  assign hit       = rvld && key_rocc && (key_rdata == key);
  assign slot_free = rvld && !key_rocc;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = go_scan ? S_SCAN : S_RESP;
        end
      end
      S_SCAN: begin
        if (idx == LAST) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: state_next = S_DECIDE;
      S_DECIDE: begin
        case (fn)
          FN_SET:  state_next = found ? (conly ? S_RESP : S_VREAD) : (freef ? S_VREAD : S_RESP);
          FN_GET:  state_next = found ? S_VREAD : S_RESP;
          default: state_next = S_RESP;
        endcase
      end
      S_VREAD: state_next = S_VWAIT;
      S_VWAIT: state_next = S_RESP;
      S_RESP: begin
        if (!out_valid || !out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state != S_IDLE);
    key_ren   = (state == S_SCAN);
    key_raddr = idx;
    key_we    = (state == S_DECIDE) && (fn == FN_SET) && !found && freef;
    key_clr   = (state == S_DECIDE) && (fn == FN_DEL) && found;
    key_waddr = found ? fidx : fridx;
    key_wdata = key;
    val_ren   = (state == S_VREAD);
    val_raddr = tgt;
    val_we    = (state == S_VWAIT) && (fn == FN_SET);
    val_waddr = tgt;
    val_wdata = (val_rdata & ~mask) | (wd & mask);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rvld      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      rvld  <= key_ren;
      if ((state == S_RESP) && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ridx <= idx;
    if (accept) begin
      fn     <= fn_in;
      key    <= eff;
      wd     <= write_data[DW-1:0];
      mask   <= mask_in;
      conly  <= create_only;
      st     <= pre_status;
      res_rd <= '0;
      found  <= 1'b0;
      freef  <= 1'b0;
      idx    <= '0;
    end
    if ((state == S_SCAN) && (idx != LAST)) begin
      idx <= idx + 1'b1;
    end
    if (hit && !found) begin
      found <= 1'b1;
      fidx  <= ridx;
    end
    if (slot_free && !freef) begin
      freef <= 1'b1;
      fridx <= ridx;
    end
    if (state == S_DECIDE) begin
      tgt <= found ? fidx : fridx;
      case (fn)
        FN_SET:  st <= found ? (conly ? ST_EXISTS : ST_OK) : (freef ? ST_OK : ST_FULL);
        FN_GET:  st <= found ? ST_OK : ST_NOT_FOUND;
        FN_DEL:  st <= found ? ST_OK : ST_NOT_FOUND;
        default: st <= ST_OK;
      endcase
    end
    if ((state == S_VWAIT) && (fn == FN_GET)) begin
      res_rd <= val_rdata & mask;
    end
    if ((state == S_RESP) && (!out_valid || !out_stall)) begin
      res_status <= st;
      res_data   <= res_rd;
    end
  end

endmodule

[design/keyed_root_entry_table_core.sv]
// Top level of the keyed root entry table: sequencer plus key and data stores.
//
//   channel  direction  handshake             beat
//   request  in         in_valid / in_stall   func, key_word, key_len, write_data,
//                                             byte_count, create_only
//   result   out        out_valid / out_stall status, read_data
//
// Invalid key, bad size and unused func skip the key scan and go straight to the result.
// Set, get, delete: one-slot-per-cycle key scan through the single comparator, then the
// registered memory read ports.
// One request at a time; in_stall is high from accept until the result is registered.
// A new request is taken while the previous result waits on out_stall.
// Reset clears all occupancy and written flags together; no clearing sweep.
module keyed_root_entry_table_core import kret_pkg::*; #(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int KEY_BYTES  = KEY_BYTES_DEF,
  parameter int DATA_BYTES = DATA_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          func,
  input  logic [WORD_W-1:0]   key_word,
  input  logic [LEN_W-1:0]    key_len,
  input  logic [WORD_W-1:0]   write_data,
  input  logic [LEN_W-1:0]    byte_count,
  input  logic                create_only,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] status,
  output logic [WORD_W-1:0]   read_data
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int KW = 8 * KEY_BYTES;
  localparam int DW = 8 * DATA_BYTES;

  status_t res_status;
  logic [DW-1:0] res_data;
  logic key_ren, key_rocc, key_we, key_clr;
  logic [IW-1:0] key_raddr, key_waddr;
  logic [KW-1:0] key_rdata, key_wdata;
  logic val_ren, val_we;
  logic [IW-1:0] val_raddr, val_waddr;
  logic [DW-1:0] val_rdata, val_wdata;

  kret_ctrl #(
    .ENTRIES(ENTRIES),
    .KEY_BYTES(KEY_BYTES),
    .DATA_BYTES(DATA_BYTES)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .func(func),
    .key_word(key_word),
    .key_len(key_len),
    .write_data(write_data),
    .byte_count(byte_count),
    .create_only(create_only),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .res_status(res_status),
    .res_data(res_data),
    .key_ren(key_ren),
    .key_raddr(key_raddr),
    .key_rdata(key_rdata),
    .key_rocc(key_rocc),
    .key_we(key_we),
    .key_clr(key_clr),
    .key_waddr(key_waddr),
    .key_wdata(key_wdata),
    .val_ren(val_ren),
    .val_raddr(val_raddr),
    .val_rdata(val_rdata),
    .val_we(val_we),
    .val_waddr(val_waddr),
    .val_wdata(val_wdata)
  );

  kret_key_store #(
    .ENTRIES(ENTRIES),
    .KW(KW)
  ) u_keys (
    .clk(clk),
    .rst(rst),
    .ren(key_ren),
    .raddr(key_raddr),
    .rdata(key_rdata),
    .rocc(key_rocc),
    .we(key_we),
    .clr(key_clr),
    .waddr(key_waddr),
    .wdata(key_wdata)
  );

  kret_val_store #(
    .ENTRIES(ENTRIES),
    .DW(DW)
  ) u_vals (
    .clk(clk),
    .rst(rst),
    .ren(val_ren),
    .raddr(val_raddr),
    .rdata(val_rdata),
    .we(val_we),
    .waddr(val_waddr),
    .wdata(val_wdata)
  );

  assign status    = res_status;
  assign read_data = WORD_W'(res_data);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("block not busy after request accept");

  a_fail_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && (res_status != ST_OK) |-> (read_data == '0))
    else $error("failed request returned data");

  a_key_wr_excl: assert property (@(posedge clk) disable iff (rst)
    !(key_we && key_clr))
    else $error("key claim and free in same cycle");

endmodule

[tb/sv/tb_keyed_root_entry_table_core.sv]
`timescale 1ns / 1ps
// Self-checking testbench for keyed_root_entry_table_core: directed and random requests.
module tb_keyed_root_entry_table_core;
  import kret_pkg::*;

  localparam int ENTRIES      = ENTRIES_DEF;
  localparam int KEY_BYTES    = KEY_BYTES_DEF;
  localparam int DATA_BYTES   = DATA_BYTES_DEF;
  localparam int KEY_POOL     = 24;
  localparam int RANDOM_FIRST = 270;
  localparam int RANDOM_LAST  = 260;
  localparam int LONG_HOLD    = 400;
  localparam int SETTLE       = ENTRIES + 24;

  typedef struct {
    func_t               func;
    logic [WORD_W-1:0]   key_word;
    logic [LEN_W-1:0]    key_len;
    logic [WORD_W-1:0]   write_data;
    logic [LEN_W-1:0]    byte_count;
    logic                create_only;
  } request_t;

  typedef struct {
    status_t             status;
    logic [WORD_W-1:0]   read_data;
  } reply_t;

  logic                clk         = 1'b0;
  logic                rst         = 1'b1;
  logic                in_valid    = 1'b0;
  logic                in_stall;
  logic [1:0]          func        = FN_NOP;
  logic [WORD_W-1:0]   key_word    = '0;
  logic [LEN_W-1:0]    key_len     = '0;
  logic [WORD_W-1:0]   write_data  = '0;
  logic [LEN_W-1:0]    byte_count  = '0;
  logic                create_only = 1'b0;
  logic                out_valid;
  logic                out_stall   = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [WORD_W-1:0]   read_data;

  request_t          request_queue[$];
  reply_t            pending_replies[$];
  request_t          cur_req;
  logic [WORD_W-1:0] table_key[ENTRIES];
  logic [WORD_W-1:0] table_data[ENTRIES];
  logic [WORD_W-1:0] pool_key[KEY_POOL];
  int                pool_len[KEY_POOL];
  int                n_sent = 0;
  int                n_results = 0;
  int                n_errors = 0;
  int                hold_left = 0;
  logic              long_hold_done = 1'b0;

  keyed_root_entry_table_core dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .key_word    (key_word),
    .key_len     (key_len),
    .write_data  (write_data),
    .byte_count  (byte_count),
    .create_only (create_only),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .read_data   (read_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [WORD_W-1:0] low_bytes(int unsigned n);
    if (n >= 8) return '1;
    return (64'd1 << (8 * n)) - 64'd1;
  endfunction

  // key stops at key_len or at its first zero byte
  function automatic logic [WORD_W-1:0] trimmed_key(logic [WORD_W-1:0] w,
                                                    logic [LEN_W-1:0] len);
    logic [WORD_W-1:0] k;
    logic              ended;
    k = '0;
    ended = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (i >= len || w[8*i +: 8] == 8'h00) ended = 1'b1;
      if (!ended) k[8*i +: 8] = w[8*i +: 8];
    end
    return k;
  endfunction

  // lowest slot holding this key; a zero key finds the lowest free slot
  function automatic int find_slot(logic [WORD_W-1:0] key);
    for (int i = 0; i < ENTRIES; i++)
      if (table_key[i] == key) return i;
    return -1;
  endfunction

  function automatic reply_t table_response(request_t r);
    reply_t            rep;
    logic [WORD_W-1:0] key;
    logic [WORD_W-1:0] m;
    int                slot;
    rep.status = ST_OK;
    rep.read_data = '0;
    if (r.func == FN_NOP) return rep;
    key = trimmed_key(r.key_word, r.key_len);
    if (r.key_len == 0 || r.key_len >= KEY_BYTES || key == '0) begin
      rep.status = ST_BAD_KEY;
    end else if (r.func == FN_SET) begin
      if (r.byte_count > DATA_BYTES) begin
        rep.status = ST_BAD_SIZE;
      end else begin
        m = low_bytes(r.byte_count);
        slot = find_slot(key);
        if (slot >= 0) begin
          if (r.create_only) rep.status = ST_EXISTS;
          else table_data[slot] = (table_data[slot] & ~m) | (r.write_data & m);
        end else begin
          slot = find_slot('0);
          if (slot < 0) begin
            rep.status = ST_FULL;
          end else begin
            table_key[slot] = key;
            table_data[slot] = (table_data[slot] & ~m) | (r.write_data & m);
          end
        end
      end
    end else if (r.func == FN_GET) begin
      slot = find_slot(key);
      if (slot < 0) rep.status = ST_NOT_FOUND;
      else rep.read_data = table_data[slot] &
                           low_bytes(r.byte_count < DATA_BYTES ? r.byte_count : DATA_BYTES);
    end else begin
      slot = find_slot(key);
      if (slot < 0) rep.status = ST_NOT_FOUND;
      else table_key[slot] = '0;
    end
    return rep;
  endfunction

  task automatic flag_error(string what, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
    n_errors++;
    $display("tb: mismatch on %s at %0t: got %0h, expected %0h", what, $realtime, got, want);
  endtask

  task automatic queue_request(func_t f, logic [WORD_W-1:0] kw, int len,
                               logic [WORD_W-1:0] wd, int cnt, logic co);
    request_t r;
    r.func = f;
    r.key_word = kw;
    r.key_len = LEN_W'(len);
    r.write_data = wd;
    r.byte_count = LEN_W'(cnt);
    r.create_only = co;
    request_queue.push_back(r);
  endtask

  function automatic request_t random_request();
    request_t          r;
    int                sel;
    int                p;
    int                shape;
    logic [WORD_W-1:0] m;
    sel = $urandom_range(99);
    if (sel < 45) r.func = FN_SET;
    else if (sel < 75) r.func = FN_GET;
    else if (sel < 95) r.func = FN_DEL;
    else r.func = FN_NOP;
    p = $urandom_range(KEY_POOL - 1);
    shape = $urandom_range(99);
    if (shape < 85) begin
      m = low_bytes(pool_len[p]);
      r.key_len = LEN_W'(pool_len[p]);
      r.key_word = (pool_key[p] & m) | ({$urandom, $urandom} & ~m);
    end else if (shape < 92) begin
      // zero byte right after the pool key, longer key_len
      m = low_bytes(pool_len[p] + 1);
      r.key_len = LEN_W'($urandom_range(7, pool_len[p] + 1));
      r.key_word = (pool_key[p] & low_bytes(pool_len[p])) | ({$urandom, $urandom} & ~m);
    end else begin
      r.key_len = LEN_W'($urandom_range(15));
      r.key_word = {$urandom, $urandom};
      if ($urandom_range(1)) r.key_word[7:0] = 8'h00;
    end
    r.write_data = {$urandom, $urandom};
    r.byte_count = ($urandom_range(99) < 85) ? LEN_W'($urandom_range(DATA_BYTES)) :
                                               LEN_W'($urandom_range(15));
    r.create_only = ($urandom_range(99) < 30);
    return r;
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (request_queue.size() != 0 || in_valid || pending_replies.size() != 0);
  endtask

  always @(posedge clk) begin : drive
    logic offer;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        pending_replies.push_back(table_response(cur_req));
        n_sent++;
      end
      if (!in_valid || !in_stall) begin
        offer = request_queue.size() != 0 &&
                ((n_sent >= 350 && n_sent < 450) || $urandom_range(99) >= 24);
        if (offer) begin
          cur_req = request_queue.pop_front();
          func <= cur_req.func;
          key_word <= cur_req.key_word;
          key_len <= cur_req.key_len;
          write_data <= cur_req.write_data;
          byte_count <= cur_req.byte_count;
          create_only <= cur_req.create_only;
        end
        in_valid <= offer;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!long_hold_done && n_results == 100) begin
      hold_left <= LONG_HOLD;
      long_hold_done <= 1'b1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !(n_results >= 350 && n_results < 450) && $urandom_range(99) < 24;
    end
  end

  always @(posedge clk) begin : check
    reply_t want;
    if (!rst && out_valid && !out_stall) begin
      n_results <= n_results + 1;
      if (pending_replies.size() == 0) begin
        flag_error("unexpected result beat", WORD_W'(status), '0);
      end else begin
        want = pending_replies.pop_front();
        if (status !== want.status)
          flag_error("status", WORD_W'(status), WORD_W'(want.status));
        if (read_data !== want.read_data) flag_error("read_data", read_data, want.read_data);
      end
    end
  end

  initial begin
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    for (int i = 0; i < ENTRIES; i++) begin
      table_key[i] = '0;
      table_data[i] = '0;
    end
    for (int i = 0; i < KEY_POOL; i++) begin
      pool_len[i] = 1 + i % 6;
      pool_key[i] = '0;
      for (int b = 0; b < 8; b++) pool_key[i][8*b +: 8] = 8'($urandom_range(255, 1));
      pool_key[i][7:0] = 8'(8'h80 + i);
    end

    queue_request(FN_GET, 64'h41, 1, 64'h0, 8, 1'b0);
    queue_request(FN_DEL, 64'h41, 1, 64'h0, 0, 1'b0);
    queue_request(FN_SET, 64'h41, 1, '1, 8, 1'b1);
    queue_request(FN_GET, 64'h41, 1, 64'h0, 8, 1'b0);
    queue_request(FN_GET, 64'h41, 1, 64'h0, 3, 1'b0);
    queue_request(FN_GET, 64'h41, 1, 64'h0, 15, 1'b0);
    queue_request(FN_GET, 64'h41, 1, 64'h0, 0, 1'b0);
    queue_request(FN_SET, 64'hFFFF_FFFF_FFFF_FF41, 1, 64'h0123_4567_89AB_CDEF, 2, 1'b0);
    queue_request(FN_GET, 64'h41, 1, 64'h0, 8, 1'b0);
    queue_request(FN_SET, 64'h41, 1, 64'h0, 8, 1'b1);
    queue_request(FN_SET, 64'h41, 0, 64'h0, 8, 1'b0);
    queue_request(FN_SET, 64'h41, KEY_BYTES, 64'h0, 8, 1'b0);
    queue_request(FN_GET, 64'h41, 15, 64'h0, 8, 1'b0);
    queue_request(FN_SET, 64'hFFFF_FF00, 4, '1, 8, 1'b0);
    queue_request(FN_SET, 64'h41, 1, '1, DATA_BYTES + 1, 1'b0);
    queue_request(FN_SET, 64'h41, 0, '1, 15, 1'b0);
    queue_request(FN_GET, 64'h42_0041, 3, 64'h0, 8, 1'b0);
    queue_request(FN_SET, '1, KEY_BYTES - 1, 64'hAAAA_5555_AAAA_5555, 8, 1'b0);
    queue_request(FN_GET, 64'h00FF_FFFF_FFFF_FFFF, KEY_BYTES - 1, 64'h0, 8, 1'b0);
    queue_request(FN_DEL, 64'h41, 1, 64'h0, 0, 1'b0);
    queue_request(FN_DEL, 64'h41, 1, 64'h0, 0, 1'b0);
    queue_request(FN_GET, 64'h41, 1, 64'h0, 8, 1'b0);
    queue_request(FN_SET, 64'h5A, 1, 64'h77, 1, 1'b1);
    queue_request(FN_GET, 64'h5A, 1, 64'h0, 8, 1'b0);
    queue_request(FN_NOP, '1, 15, '1, 15, 1'b1);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    wait_drained();
    for (int i = 0; i < RANDOM_FIRST; i++) request_queue.push_back(random_request());
    // sender pauses here until the block has answered everything
    wait_drained();
    for (int i = 0; i < RANDOM_LAST; i++) request_queue.push_back(random_request());
    wait_drained();
    repeat (SETTLE) @(negedge clk);

    if (n_errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

[keyed_root_entry_table_core.f]
design/kret_pkg.sv
design/kret_key_store.sv
design/kret_val_store.sv
design/kret_ctrl.sv
design/keyed_root_entry_table_core.sv
tb/sv/tb_keyed_root_entry_table_core.sv
